### rtl/mnst_pkg.sv
// Package with the shared types and MIDI message codes of the note sustain tracker.
package mnst_pkg;

  // Velocity or level of one note.
  typedef logic [6:0] level_t;

  // Request kind carried by req_type.
  typedef enum logic {
    ReqApply = 1'b0,
    ReqRead  = 1'b1
  } req_type_e;

  // Upper nibble of the MIDI status byte.
  typedef enum logic [3:0] {
    KindNoteOff = 4'h8,
    KindNoteOn  = 4'h9,
    KindCtrl    = 4'hB,
    KindBend    = 4'hE
  } status_kind_e;

  // Controller number of the sustain pedal and its on threshold.
  localparam logic [6:0] SustainCtrl   = 7'd64;
  localparam logic [6:0] SustainThresh = 7'd64;

endpackage

### rtl/mnst_level_mem.sv
// Level memory of the note sustain tracker: one write and one registered read port.
module mnst_level_mem #(
  parameter int unsigned Depth = 128,
  parameter int unsigned AddrW = 7
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [AddrW-1:0]     wr_addr_i,
  input  mnst_pkg::level_t     wr_data_i,
  input  logic                 rd_en_i,
  input  logic [AddrW-1:0]     rd_addr_i,
  output mnst_pkg::level_t     rd_data_o
);
  import mnst_pkg::*;

  level_t mem_q [Depth];
  level_t rd_data_q;

  // Write port and registered read; a read of the address being written returns the new data.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/midi_note_sustain_tracker.sv
// Top level of the MIDI note tracker with sustain pedal handling.
//
// The input channel takes one request per transfer: either a framed MIDI message
// (note-off, note-on, controller 64, pitch wheel; channel nibble ignored) or a
// read of one note's state. Every request produces exactly one result on the
// output channel: the note named by the first data byte, its level and
// release-pending mark after the request, the sustain flag and the raw bend.
// A request taken into the input stage is applied when it leaves that stage,
// where its result enters the output register; out_valid_o is high from then.
// Throughput: one request per cycle unless the receiver stalls, bounded by the
// single write port of the note level memory and its one registered read, which
// is launched on transfer. Pending marks and live flags are flip-flops, so all
// pending notes are released at once on pedal-up. Reset clears all notes, marks,
// sustain and bend at once; no clearing pass is needed. When the receiver stalls,
// the result holds in the output register, one more request waits in the input
// stage, and in_ready_o then drops until the output moves on.
module midi_note_sustain_tracker #(
  parameter int unsigned NOTE_COUNT = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [7:0]  status_byte_i,
  input  logic [6:0]  data_one_i,
  input  logic [6:0]  data_two_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  note_index_o,
  output logic [6:0]  note_level_o,
  output logic        release_pending_o,
  output logic        sustain_held_o,
  output logic [13:0] bend_raw_o
);
  import mnst_pkg::*;

  localparam int unsigned IdxW    = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
  localparam logic [7:0]  NoteLim = 8'(NOTE_COUNT);

  // Input stage.
  logic        s1_valid_q;
  logic        s1_req_q;
  logic [3:0]  s1_kind_q;
  logic [6:0]  s1_d1_q;
  logic [6:0]  s1_d2_q;
  logic        s1_adv;
  logic        in_xfer;

  // Note state.
  logic [NOTE_COUNT-1:0] live_q, live_d;
  logic [NOTE_COUNT-1:0] pend_q, pend_d;
  logic                  sustain_q, sustain_d;
  logic [13:0]           bend_q, bend_d;

  // Decode of the staged request.
  logic            in_range;
  logic [IdxW-1:0] idx;
  logic            is_apply;
  logic            note_on;
  logic            note_off;
  logic            pedal;
  logic            pedal_on;
  logic            pedal_off;
  logic            bend_wr;
  logic            in_range_i;

  // Level memory.
  level_t rd_level;
  level_t level_res;

  // Output register.
  logic        out_valid_q;
  logic [6:0]  out_index_q;
  logic [6:0]  out_level_q;
  logic        out_pend_q;
  logic        out_sus_q;
  logic [13:0] out_bend_q;

  // Handshake: the staged request moves on whenever the output register is free or drains.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign in_range_i = ({1'b0, data_one_i} < NoteLim);

  // Input stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_req_q  <= req_type_i;
      s1_kind_q <= status_byte_i[7:4];
      s1_d1_q   <= data_one_i;
      s1_d2_q   <= data_two_i;
    end
  end

  // Message decode.
  assign idx       = s1_d1_q[IdxW-1:0];
  assign in_range  = ({1'b0, s1_d1_q} < NoteLim);
  assign is_apply  = (s1_req_q == ReqApply);
  assign note_on   = is_apply && (s1_kind_q == KindNoteOn) && (s1_d2_q != 7'd0);
  assign note_off  = is_apply && ((s1_kind_q == KindNoteOff) ||
                                  ((s1_kind_q == KindNoteOn) && (s1_d2_q == 7'd0)));
  assign pedal     = is_apply && (s1_kind_q == KindCtrl) && (s1_d1_q == SustainCtrl);
  assign pedal_on  = pedal && (s1_d2_q >= SustainThresh);
  assign pedal_off = pedal && (s1_d2_q < SustainThresh);
  assign bend_wr   = is_apply && (s1_kind_q == KindBend);

  // Next note state: a live flag gates each stored level, a pending mark awaits pedal-up.
  always_comb begin
    live_d    = live_q;
    pend_d    = pend_q;
    sustain_d = sustain_q;
    bend_d    = bend_q;
    if (pedal_off) begin
      live_d    = live_q & ~pend_q;
      pend_d    = '0;
      sustain_d = 1'b0;
    end
    if (pedal_on) begin
      sustain_d = 1'b1;
    end
    if (note_on && in_range) begin
      live_d[idx] = 1'b1;
      pend_d[idx] = 1'b0;
    end
    if (note_off && in_range) begin
      if (sustain_q) begin
        pend_d[idx] = 1'b1;
      end else begin
        live_d[idx] = 1'b0;
      end
    end
    if (bend_wr) begin
      bend_d = {s1_d2_q, s1_d1_q};
    end
  end

  // State commits when the request's result enters the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q    <= '0;
      pend_q    <= '0;
      sustain_q <= 1'b0;
      bend_q    <= '0;
    end else if (s1_adv) begin
      live_q    <= live_d;
      pend_q    <= pend_d;
      sustain_q <= sustain_d;
      bend_q    <= bend_d;
    end
  end

  // Level memory, read on input transfer and written by a committed note-on.
  mnst_level_mem #(
    .Depth (NOTE_COUNT),
    .AddrW (IdxW)
  ) u_level_mem (
    .clk_i     (clk_i),
    .wr_en_i   (s1_adv && note_on && in_range),
    .wr_addr_i (idx),
    .wr_data_i (s1_d2_q),
    .rd_en_i   (in_xfer && in_range_i),
    .rd_addr_i (data_one_i[IdxW-1:0]),
    .rd_data_o (rd_level)
  );

  // Level reported after the step.
  always_comb begin
    level_res = '0;
    if (in_range && live_d[idx]) begin
      level_res = note_on ? s1_d2_q : rd_level;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_index_q <= s1_d1_q;
      out_level_q <= level_res;
      out_pend_q  <= in_range && pend_d[idx];
      out_sus_q   <= sustain_d;
      out_bend_q  <= bend_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign note_index_o      = out_index_q;
  assign note_level_o      = out_level_q;
  assign release_pending_o = out_pend_q;
  assign sustain_held_o    = out_sus_q;
  assign bend_raw_o        = out_bend_q;

endmodule

### rtl/mnst_checker.sv
// Port checker of the note sustain tracker and its bind to the top level.
module mnst_checker #(
  parameter int unsigned NOTE_COUNT = 128
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        req_type_i,
  input logic [7:0]  status_byte_i,
  input logic [6:0]  data_one_i,
  input logic [6:0]  data_two_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [6:0]  note_index_o,
  input logic [6:0]  note_level_o,
  input logic        release_pending_o,
  input logic        sustain_held_o,
  input logic [13:0] bend_raw_o
);
  import mnst_pkg::*;

  localparam logic [7:0] NoteLim = 8'(NOTE_COUNT);

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(note_index_o) &&
      $stable(note_level_o) && $stable(release_pending_o) &&
      $stable(sustain_held_o) && $stable(bend_raw_o))
    else $error("stalled result changed or was dropped");

  // A waiting request stays offered with its payload unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(req_type_i) &&
      $stable(status_byte_i) && $stable(data_one_i) && $stable(data_two_i))
    else $error("waiting request changed or was withdrawn");

  // A note can only await release while the pedal is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && release_pending_o |-> sustain_held_o)
    else $error("release pending without sustain held");

  // With the output register empty, the input side always takes a transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output register is empty");

  // A note outside the tracked range reports no level and no mark.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ({1'b0, note_index_o} >= NoteLim) |->
      (note_level_o == 7'd0) && !release_pending_o)
    else $error("untracked note reports state");

endmodule

bind midi_note_sustain_tracker mnst_checker #(.NOTE_COUNT(NOTE_COUNT)) u_mnst_checker (.*);
